// ----- rtl/bfpa_pkg.sv -----
package bfpa_pkg;

    localparam int MAX_BLOCKS = 64;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int LINK_W     = $clog2(MAX_BLOCKS + 1);
    localparam int ADDR_W     = 64;
    localparam int SIZE_W     = 40;
    localparam int ALIGN_SH   = 9;
    localparam int CFG_IDX_W  = 1;

    localparam logic [LINK_W-1:0] NO_BLK = LINK_W'(MAX_BLOCKS);

    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOFIT   = 2'd1,
        ST_NULL    = 2'd2,
        ST_UNKNOWN = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_SCAN, S_A_EVAL, S_A_MARK, S_A_SPLIT1, S_A_SPLIT2,
        S_F_EVAL, S_F_LINK, S_F_MN, S_F_CHKP, S_F_MP, S_DONE
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_SCAN, OP_A_RD, OP_A_MARK, OP_A_SPLIT1, OP_A_SPLIT2,
        OP_NOFIT, OP_NULL, OP_UNKNOWN, OP_F_CLR, OP_F_LINK, OP_F_MN, OP_F_RDP, OP_F_MP
    } op_t;

    typedef struct packed {
        op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic is_free;
        logic addr_null;
        logic scan_done;
        logic found;
        logic do_split;
        logic nb_free;
        logic p_free;
    } dp_stat_t;

endpackage

// ----- rtl/bfpa_ctrl.sv -----
module bfpa_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              cfg_ready,
    input  bfpa_pkg::dp_stat_t stat,
    output bfpa_pkg::dp_cmd_t  cmd
);
    import bfpa_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) state_next = S_DISPATCH;
            end
            S_DISPATCH: begin
                if (stat.is_free && stat.addr_null) state_next = S_DONE;
                else state_next = S_SCAN;
            end
            S_SCAN: begin
                if (stat.scan_done) state_next = stat.is_free ? S_F_EVAL : S_A_EVAL;
            end
            S_A_EVAL: state_next = stat.found ? S_A_MARK : S_DONE;
            S_A_MARK: state_next = stat.do_split ? S_A_SPLIT1 : S_DONE;
            S_A_SPLIT1: state_next = S_A_SPLIT2;
            S_A_SPLIT2: state_next = S_DONE;
            S_F_EVAL: state_next = stat.found ? S_F_LINK : S_DONE;
            S_F_LINK: state_next = stat.nb_free ? S_F_MN : S_F_CHKP;
            S_F_MN: state_next = S_F_CHKP;
            S_F_CHKP: state_next = stat.p_free ? S_F_MP : S_DONE;
            S_F_MP: state_next = S_DONE;
            S_DONE: begin
                if (m_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd.op    = OP_NONE;
        s_ready   = 1'b0;
        cfg_ready = 1'b0;
        m_valid   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready   = 1'b1;
                cfg_ready = 1'b1;
                if (s_valid) cmd.op = OP_LOAD;
            end
            S_DISPATCH: begin
                if (stat.is_free && stat.addr_null) cmd.op = OP_NULL;
            end
            S_SCAN: cmd.op = OP_SCAN;
            S_A_EVAL: cmd.op = stat.found ? OP_A_RD : OP_NOFIT;
            S_A_MARK: cmd.op = OP_A_MARK;
            S_A_SPLIT1: cmd.op = OP_A_SPLIT1;
            S_A_SPLIT2: cmd.op = OP_A_SPLIT2;
            S_F_EVAL: cmd.op = stat.found ? OP_F_CLR : OP_UNKNOWN;
            S_F_LINK: cmd.op = OP_F_LINK;
            S_F_MN: cmd.op = OP_F_MN;
            S_F_CHKP: begin
                if (stat.p_free) cmd.op = OP_F_RDP;
            end
            S_F_MP: cmd.op = OP_F_MP;
            S_DONE: m_valid = 1'b1;
            default: cmd.op = OP_NONE;
        endcase
    end

endmodule

// ----- rtl/bfpa_datapath.sv -----
module bfpa_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [bfpa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bfpa_pkg::ADDR_W-1:0]         cfg_data,
    input  logic                                in_action,
    input  logic [bfpa_pkg::SIZE_W-1:0]         in_req_size,
    input  logic [bfpa_pkg::ADDR_W-1:0]         in_address,
    output logic [bfpa_pkg::ADDR_W-1:0]         out_granted_addr,
    output logic [1:0]                          out_status,
    input  bfpa_pkg::dp_cmd_t                   cmd,
    output bfpa_pkg::dp_stat_t                  stat
);
    import bfpa_pkg::*;

    logic [SIZE_W-1:0] off_mem  [MAX_BLOCKS];
    logic [SIZE_W-1:0] len_mem  [MAX_BLOCKS];
    logic [LINK_W-1:0] next_mem [MAX_BLOCKS];
    logic [LINK_W-1:0] prev_mem [MAX_BLOCKS];

    logic [MAX_BLOCKS-1:0] live_reg, in_use_reg;

    logic [ADDR_W-1:0] base_reg;
    logic              is_free_reg, addr_null_reg;
    logic [SIZE_W:0]   need_reg;
    logic [ADDR_W-1:0] off_req_reg;
    logic [LINK_W-1:0] cnt_reg;
    logic              cmp_vld_reg;
    logic [IDX_W-1:0]  cmp_idx_reg;
    logic              found_reg, spare_found_reg;
    logic [IDX_W-1:0]  best_idx_reg, spare_reg;
    logic [SIZE_W-1:0] best_len_reg, best_off_reg;
    logic [LINK_W-1:0] nx_reg, hn_reg, hp_reg;
    logic [ADDR_W-1:0] granted_reg;
    status_t           status_reg;

    logic [SIZE_W-1:0] off_q, len_q;
    logic [LINK_W-1:0] next_q, prev_q;
    logic [IDX_W-1:0]  rd_addr;

    logic [SIZE_W:0]   need_sum, need_calc;
    logic              hit_cand, fit_cand, better;
    logic [SIZE_W+1:0] need_x2;

    logic              off_we, len_we, next_we, prev_we;
    logic [IDX_W-1:0]  off_wa, len_wa, next_wa, prev_wa;
    logic [SIZE_W-1:0] off_wd, len_wd;
    logic [LINK_W-1:0] next_wd, prev_wd;
    logic [SIZE_W-1:0] merged_len;
    logic              cfg_size_we;

    assign cfg_size_we = cfg_we && (cfg_index == CFG_POOL_SIZE);

    // round up to 512 bytes, zero taken as one unit
    assign need_sum  = {1'b0, in_req_size} + (SIZE_W+1)'((1 << ALIGN_SH) - 1);
    assign need_calc = (in_req_size == '0) ? (SIZE_W+1)'(1 << ALIGN_SH)
                                           : {need_sum[SIZE_W:ALIGN_SH], ALIGN_SH'(0)};

    assign need_x2 = {need_reg, 1'b0};

    always_comb begin
        rd_addr = cnt_reg[IDX_W-1:0];
        case (cmd.op)
            OP_A_RD, OP_A_MARK, OP_F_CLR: rd_addr = best_idx_reg;
            OP_F_LINK:                    rd_addr = next_q[IDX_W-1:0];
            OP_F_RDP:                     rd_addr = hp_reg[IDX_W-1:0];
            default:                      rd_addr = cnt_reg[IDX_W-1:0];
        endcase
    end

    // scan compare on the registered read word of the entry in cmp_idx_reg
    assign hit_cand = live_reg[cmp_idx_reg] && in_use_reg[cmp_idx_reg]
                      && (off_req_reg[ADDR_W-1:SIZE_W] == '0)
                      && (off_req_reg[SIZE_W-1:0] == off_q);
    assign fit_cand = live_reg[cmp_idx_reg] && !in_use_reg[cmp_idx_reg]
                      && ({1'b0, len_q} >= need_reg);
    assign better   = !found_reg || (len_q < best_len_reg)
                      || ((len_q == best_len_reg) && (off_q < best_off_reg));

    assign merged_len = len_q + best_len_reg;

    always_comb begin
        off_we = 1'b0; off_wa = '0; off_wd = '0;
        len_we = 1'b0; len_wa = '0; len_wd = '0;
        next_we = 1'b0; next_wa = '0; next_wd = '0;
        prev_we = 1'b0; prev_wa = '0; prev_wd = '0;
        if (cfg_size_we) begin
            off_we = 1'b1;
            len_we = 1'b1; len_wd = cfg_data[SIZE_W-1:0];
            next_we = 1'b1; next_wd = NO_BLK;
            prev_we = 1'b1; prev_wd = NO_BLK;
        end else begin
            case (cmd.op)
                OP_A_SPLIT1: begin
                    off_we = 1'b1; off_wa = spare_reg;
                    off_wd = best_off_reg + need_reg[SIZE_W-1:0];
                    len_we = 1'b1; len_wa = spare_reg;
                    len_wd = best_len_reg - need_reg[SIZE_W-1:0];
                    next_we = 1'b1; next_wa = spare_reg; next_wd = nx_reg;
                    prev_we = 1'b1; prev_wa = spare_reg;
                    prev_wd = LINK_W'(best_idx_reg);
                end
                OP_A_SPLIT2: begin
                    len_we = 1'b1; len_wa = best_idx_reg; len_wd = need_reg[SIZE_W-1:0];
                    next_we = 1'b1; next_wa = best_idx_reg; next_wd = LINK_W'(spare_reg);
                    prev_we = (nx_reg < NO_BLK); prev_wa = nx_reg[IDX_W-1:0];
                    prev_wd = LINK_W'(spare_reg);
                end
                OP_F_MN: begin
                    len_we = 1'b1; len_wa = best_idx_reg; len_wd = merged_len;
                    next_we = 1'b1; next_wa = best_idx_reg; next_wd = next_q;
                    prev_we = (next_q < NO_BLK); prev_wa = next_q[IDX_W-1:0];
                    prev_wd = LINK_W'(best_idx_reg);
                end
                OP_F_MP: begin
                    len_we = 1'b1; len_wa = hp_reg[IDX_W-1:0]; len_wd = merged_len;
                    next_we = 1'b1; next_wa = hp_reg[IDX_W-1:0]; next_wd = hn_reg;
                    prev_we = (hn_reg < NO_BLK); prev_wa = hn_reg[IDX_W-1:0];
                    prev_wd = hp_reg;
                end
                default: off_we = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (off_we) off_mem[off_wa] <= off_wd;
        off_q <= off_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (len_we) len_mem[len_wa] <= len_wd;
        len_q <= len_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (next_we) next_mem[next_wa] <= next_wd;
        next_q <= next_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (prev_we) prev_mem[prev_wa] <= prev_wd;
        prev_q <= prev_mem[rd_addr];
    end

    // entry flags and pool base
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_reg   <= '0;
            in_use_reg <= '0;
            base_reg   <= '0;
        end else if (cfg_we) begin
            if (cfg_index == CFG_POOL_BASE) begin
                base_reg <= cfg_data;
            end else begin
                live_reg   <= MAX_BLOCKS'(1);
                in_use_reg <= '0;
            end
        end else begin
            case (cmd.op)
                OP_A_MARK: in_use_reg[best_idx_reg] <= 1'b1;
                OP_A_SPLIT1: begin
                    live_reg[spare_reg]   <= 1'b1;
                    in_use_reg[spare_reg] <= 1'b0;
                end
                OP_F_CLR: in_use_reg[best_idx_reg] <= 1'b0;
                OP_F_MN:  live_reg[hn_reg[IDX_W-1:0]] <= 1'b0;
                OP_F_MP:  live_reg[best_idx_reg] <= 1'b0;
                default: live_reg <= live_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            cmp_vld_reg <= 1'b0;
        end else if (cmd.op == OP_LOAD) begin
            cnt_reg     <= '0;
            cmp_vld_reg <= 1'b0;
        end else if (cmd.op == OP_SCAN) begin
            cmp_vld_reg <= (cnt_reg < NO_BLK);
            cmp_idx_reg <= cnt_reg[IDX_W-1:0];
            if (cnt_reg < NO_BLK) cnt_reg <= cnt_reg + 1'b1;
        end else begin
            cmp_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                is_free_reg     <= in_action;
                addr_null_reg   <= (in_address == '0);
                need_reg        <= need_calc;
                off_req_reg     <= in_address - base_reg;
                found_reg       <= 1'b0;
                spare_found_reg <= 1'b0;
            end
            OP_SCAN: begin
                if (cmp_vld_reg) begin
                    if (is_free_reg) begin
                        if (hit_cand && !found_reg) begin
                            found_reg    <= 1'b1;
                            best_idx_reg <= cmp_idx_reg;
                            best_len_reg <= len_q;
                        end
                    end else begin
                        if (!live_reg[cmp_idx_reg] && !spare_found_reg) begin
                            spare_found_reg <= 1'b1;
                            spare_reg       <= cmp_idx_reg;
                        end
                        if (fit_cand && better) begin
                            found_reg    <= 1'b1;
                            best_idx_reg <= cmp_idx_reg;
                            best_len_reg <= len_q;
                            best_off_reg <= off_q;
                        end
                    end
                end
            end
            OP_A_MARK: begin
                nx_reg      <= next_q;
                granted_reg <= base_reg + ADDR_W'(best_off_reg);
                status_reg  <= ST_OK;
            end
            OP_NOFIT: begin
                granted_reg <= '0;
                status_reg  <= ST_NOFIT;
            end
            OP_NULL: begin
                granted_reg <= '0;
                status_reg  <= ST_NULL;
            end
            OP_UNKNOWN: begin
                granted_reg <= '0;
                status_reg  <= ST_UNKNOWN;
            end
            OP_F_CLR: begin
                granted_reg <= '0;
                status_reg  <= ST_OK;
            end
            OP_F_LINK: begin
                hn_reg <= next_q;
                hp_reg <= prev_q;
            end
            OP_F_MN: begin
                best_len_reg <= merged_len;
                hn_reg       <= next_q;
            end
            default: best_idx_reg <= best_idx_reg;
        endcase
    end

    assign stat.is_free   = is_free_reg;
    assign stat.addr_null = addr_null_reg;
    assign stat.scan_done = cmp_vld_reg && (cmp_idx_reg == IDX_W'(MAX_BLOCKS - 1));
    assign stat.found     = found_reg;
    assign stat.do_split  = spare_found_reg && (need_x2 <= {2'b00, best_len_reg});
    assign stat.nb_free   = (next_q < NO_BLK) && live_reg[next_q[IDX_W-1:0]]
                            && !in_use_reg[next_q[IDX_W-1:0]];
    assign stat.p_free    = (hp_reg < NO_BLK) && live_reg[hp_reg[IDX_W-1:0]]
                            && !in_use_reg[hp_reg[IDX_W-1:0]];

    assign out_granted_addr = granted_reg;
    assign out_status       = status_reg;

endmodule

// ----- rtl/best_fit_pool_allocator_top.sv -----
// channel  direction  ports
// s_       in         s_valid s_ready s_action s_req_size s_address
// m_       out        m_valid m_ready m_granted_addr m_status
// cfg_     in         cfg_valid cfg_ready cfg_index cfg_data
// one word at a time: an allocate or a free scans all 64 table entries through
// the registered read port, then makes any split or merge updates; a free of
// null skips the scan.
// aresetn is synchronous; the table is empty until pool_size is written.
// while a result waits on m_ready no new word or config write is taken.
module best_fit_pool_allocator_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_action,
    input  logic [bfpa_pkg::SIZE_W-1:0]        s_req_size,
    input  logic [bfpa_pkg::ADDR_W-1:0]        s_address,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [bfpa_pkg::ADDR_W-1:0]        m_granted_addr,
    output logic [1:0]                         m_status,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bfpa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bfpa_pkg::ADDR_W-1:0]        cfg_data
);
    import bfpa_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    bfpa_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cfg_ready (cfg_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    bfpa_datapath u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_valid && cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_action        (s_action),
        .in_req_size      (s_req_size),
        .in_address       (s_address),
        .out_granted_addr (m_granted_addr),
        .out_status       (m_status),
        .cmd              (cmd),
        .stat             (stat)
    );

endmodule
